[sv/pca_pkg.sv]
// Package for polar_complex_alu: widths, commands, CORDIC angle table and
// shared constants. No dependencies.
package pca_pkg;

    localparam int DefStages   = 16;
    localparam int DefFracBits = 16;
    localparam int GuardBits   = 8;
    localparam int MaxStages   = 24;

    typedef enum logic [1:0] {
        CMD_MUL  = 2'd0,
        CMD_SUB  = 2'd1,
        CMD_RECT = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    localparam logic signed [35:0] PiQ32      = 36'sd13493037705;
    localparam logic signed [35:0] HalfPiQ32  = 36'sd6746518852;
    localparam logic [31:0]        GainInvQ32 = 32'd2608131496;

    function automatic logic signed [35:0] atan_q32(input int i);
        logic signed [35:0] r;
        unique case (i)
            0:  r = 36'sd3373259426;
            1:  r = 36'sd1991351318;
            2:  r = 36'sd1052175346;
            3:  r = 36'sd534100635;
            4:  r = 36'sd268086748;
            5:  r = 36'sd134174063;
            6:  r = 36'sd67103403;
            7:  r = 36'sd33553749;
            8:  r = 36'sd16777131;
            9:  r = 36'sd8388597;
            10: r = 36'sd4194303;
            11: r = 36'sd2097152;
            12: r = 36'sd1048576;
            13: r = 36'sd524288;
            14: r = 36'sd262144;
            15: r = 36'sd131072;
            16: r = 36'sd65536;
            17: r = 36'sd32768;
            18: r = 36'sd16384;
            19: r = 36'sd8192;
            20: r = 36'sd4096;
            21: r = 36'sd2048;
            22: r = 36'sd1024;
            23: r = 36'sd512;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

[sv/pca_front.sv]
// Front end of polar_complex_alu: accepts a transfer, decodes the command,
// wraps angles to Q.32. Depends on pca_pkg.
module pca_front #(
    parameter int FRAC_BITS = pca_pkg::DefFracBits
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [1:0]               i_command,
    input  logic [FRAC_BITS+7:0]     i_radius_a,
    input  logic signed [FRAC_BITS+2:0] i_angle_a,
    input  logic [FRAC_BITS+7:0]     i_radius_b,
    input  logic signed [FRAC_BITS+2:0] i_angle_b,
    output logic                     o_valid,
    input  logic                     i_stall,
    output pca_pkg::t_cmd            o_cmd,
    output logic [FRAC_BITS+7:0]     o_ra,
    output logic [FRAC_BITS+7:0]     o_rb,
    output logic signed [35:0]       o_za,
    output logic signed [35:0]       o_zb
);
    localparam int Sh = 32 - FRAC_BITS;

    logic                   r_valid;
    pca_pkg::t_cmd          r_cmd;
    logic [FRAC_BITS+7:0]   r_ra, r_rb;
    logic signed [35:0]     r_za, r_zb;
    logic signed [35:0]     n_za, n_zb;

    function automatic logic signed [35:0] wrap(input logic signed [35:0] z);
        logic signed [35:0] w;
        w = z;
        if (w > pca_pkg::PiQ32) w = w - (pca_pkg::PiQ32 <<< 1);
        else if (w <= -pca_pkg::PiQ32) w = w + (pca_pkg::PiQ32 <<< 1);
        return w;
    endfunction

    assign n_za = wrap(36'(i_angle_a) <<< Sh);
    assign n_zb = wrap(36'(i_angle_b) <<< Sh);
    assign o_stall = r_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
        if (!o_stall && i_valid) begin
            r_cmd <= pca_pkg::t_cmd'(i_command);
            r_ra  <= i_radius_a;
            r_rb  <= i_radius_b;
            r_za  <= n_za;
            r_zb  <= n_zb;
        end
    end

    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;
    assign o_ra    = r_ra;
    assign o_rb    = r_rb;
    assign o_za    = r_za;
    assign o_zb    = r_zb;
endmodule

[sv/pca_queue.sv]
// Two-entry queue between front and back of polar_complex_alu.
// No dependencies.
module pca_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_stall,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    input  logic         i_stall,
    output logic [W-1:0] o_data
);
    logic [W-1:0] r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;
    logic         wr, rd;

    assign o_stall = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign wr = i_valid && !o_stall;
    assign rd = o_valid && !i_stall;
    assign o_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= ~r_wp;
            if (rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(wr) - 2'(rd);
        end
        if (wr) r_mem[r_wp] <= i_data;
    end
endmodule

[sv/pca_back.sv]
// Back end of polar_complex_alu: product, pipelined CORDIC rotation,
// subtraction, vectoring and output rounding. Depends on pca_pkg.
module pca_back #(
    parameter int STAGES    = pca_pkg::DefStages,
    parameter int FRAC_BITS = pca_pkg::DefFracBits
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  pca_pkg::t_cmd               i_cmd,
    input  logic [FRAC_BITS+7:0]        i_ra,
    input  logic [FRAC_BITS+7:0]        i_rb,
    input  logic signed [35:0]          i_za,
    input  logic signed [35:0]          i_zb,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [FRAC_BITS+7:0]        o_radius_out,
    output logic signed [FRAC_BITS+2:0] o_angle_out,
    output logic signed [FRAC_BITS+9:0] o_x_out,
    output logic signed [FRAC_BITS+9:0] o_y_out,
    output logic                        o_overflow
);
    localparam int RB  = FRAC_BITS + 8;
    localparam int AB  = FRAC_BITS + 3;
    localparam int XB  = FRAC_BITS + 10;
    localparam int G   = pca_pkg::GuardBits;
    localparam int DW  = RB + G + 5;
    localparam int Sh  = 32 - FRAC_BITS;
    localparam logic signed [35:0] Pi = pca_pkg::PiQ32;
    localparam logic signed [AB+1:0] PA =
        (AB+2)'((pca_pkg::PiQ32 + (36'sd1 <<< (Sh-1))) >>> Sh);

    typedef struct packed {
        pca_pkg::t_cmd        cmd;
        logic [RB-1:0]        prod;
        logic signed [35:0]   zs;
    } t_side;

    logic adv;
    assign o_stall = o_valid && i_stall;
    assign adv = !o_stall;

    function automatic logic [RB+G+1:0] gain(input logic [RB+G+1:0] u);
        logic [RB+G+33:0] a;
        logic [47:0]      b;
        a = (RB+G+34)'(u >> 16) * pca_pkg::GainInvQ32;
        b = 48'(u[15:0]) * pca_pkg::GainInvQ32;
        return (RB+G+2)'((a + (RB+G+34)'(b >> 16) + 32768) >> 16);
    endfunction

    // stage 0: gain correction, product, angle sum
    logic                     r_v0;
    t_side                    r_s0;
    logic signed [DW-1:0]     r_xa0, r_xb0;
    logic signed [35:0]       r_za0, r_zb0;
    logic [2*RB-1:0]          n_prod;
    logic [2*RB-1:0]          n_pr;
    logic signed [35:0]       n_zs;

    assign n_prod = (2*RB)'(i_ra) * (2*RB)'(i_rb);
    assign n_pr = n_prod + (2*RB)'(1 << (FRAC_BITS-1));
    always_comb begin
        n_zs = i_za + i_zb;
        if (n_zs > Pi) n_zs = n_zs - (Pi <<< 1);
        else if (n_zs <= -Pi) n_zs = n_zs + (Pi <<< 1);
    end

    logic ovf_mul;
    assign ovf_mul = |n_pr[2*RB-1:RB+FRAC_BITS];

    logic r_ovm0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v0 <= 1'b0;
        else if (adv) r_v0 <= i_valid;
        if (adv) begin
            r_s0.cmd  <= i_cmd;
            r_s0.prod <= ovf_mul ? {RB{1'b1}} : n_pr[RB+FRAC_BITS-1:FRAC_BITS];
            r_s0.zs   <= n_zs;
            r_ovm0    <= ovf_mul;
            r_xa0     <= DW'($signed({1'b0, gain((RB+G+2)'({i_ra, {G{1'b0}}}))}));
            r_xb0     <= DW'($signed({1'b0, gain((RB+G+2)'({i_rb, {G{1'b0}}}))}));
            r_za0     <= i_za;
            r_zb0     <= i_zb;
        end
    end

    // stage 1: quadrant fold
    logic                 r_v1, r_ovm1;
    t_side                r_s1;
    logic signed [DW-1:0] r_xa1, r_xb1;
    logic signed [35:0]   r_za1, r_zb1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else if (adv) r_v1 <= r_v0;
        if (adv) begin
            r_s1 <= r_s0; r_ovm1 <= r_ovm0;
            r_xa1 <= r_xa0; r_za1 <= r_za0;
            r_xb1 <= r_xb0; r_zb1 <= r_zb0;
            if (r_za0 > pca_pkg::HalfPiQ32) begin
                r_za1 <= r_za0 - Pi; r_xa1 <= -r_xa0;
            end else if (r_za0 < -pca_pkg::HalfPiQ32) begin
                r_za1 <= r_za0 + Pi; r_xa1 <= -r_xa0;
            end
            if (r_zb0 > pca_pkg::HalfPiQ32) begin
                r_zb1 <= r_zb0 - Pi; r_xb1 <= -r_xb0;
            end else if (r_zb0 < -pca_pkg::HalfPiQ32) begin
                r_zb1 <= r_zb0 + Pi; r_xb1 <= -r_xb0;
            end
        end
    end

    // rotation pipeline
    logic                 r_rv [STAGES+1];
    logic                 r_rovm [STAGES+1];
    t_side                r_rs [STAGES+1];
    logic signed [DW-1:0] r_rxa [STAGES+1], r_rya [STAGES+1];
    logic signed [DW-1:0] r_rxb [STAGES+1], r_ryb [STAGES+1];
    logic signed [35:0]   r_rza [STAGES+1], r_rzb [STAGES+1];

    assign r_rv[0] = r_v1;  assign r_rs[0] = r_s1;  assign r_rovm[0] = r_ovm1;
    assign r_rxa[0] = r_xa1; assign r_rya[0] = '0; assign r_rza[0] = r_za1;
    assign r_rxb[0] = r_xb1; assign r_ryb[0] = '0; assign r_rzb[0] = r_zb1;

    for (genvar i = 0; i < STAGES; i++) begin : g_rot
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_rv[i+1] <= 1'b0;
            else if (adv) r_rv[i+1] <= r_rv[i];
            if (adv) begin
                r_rs[i+1] <= r_rs[i]; r_rovm[i+1] <= r_rovm[i];
                if (r_rza[i] >= 0) begin
                    r_rxa[i+1] <= r_rxa[i] - (r_rya[i] >>> i);
                    r_rya[i+1] <= r_rya[i] + (r_rxa[i] >>> i);
                    r_rza[i+1] <= r_rza[i] - pca_pkg::atan_q32(i);
                end else begin
                    r_rxa[i+1] <= r_rxa[i] + (r_rya[i] >>> i);
                    r_rya[i+1] <= r_rya[i] - (r_rxa[i] >>> i);
                    r_rza[i+1] <= r_rza[i] + pca_pkg::atan_q32(i);
                end
                if (r_rzb[i] >= 0) begin
                    r_rxb[i+1] <= r_rxb[i] - (r_ryb[i] >>> i);
                    r_ryb[i+1] <= r_ryb[i] + (r_rxb[i] >>> i);
                    r_rzb[i+1] <= r_rzb[i] - pca_pkg::atan_q32(i);
                end else begin
                    r_rxb[i+1] <= r_rxb[i] + (r_ryb[i] >>> i);
                    r_ryb[i+1] <= r_ryb[i] - (r_rxb[i] >>> i);
                    r_rzb[i+1] <= r_rzb[i] + pca_pkg::atan_q32(i);
                end
            end
        end
    end

    // difference and vectoring pre-fold
    logic                 r_dv, r_dovm, r_dzero;
    t_side                r_ds;
    logic signed [DW-1:0] r_rxo, r_ryo;
    logic signed [DW:0]   r_dx, r_dy;
    logic signed [35:0]   r_dz;
    logic signed [DW:0]   n_dx, n_dy;
    assign n_dx = (DW+1)'(r_rxa[STAGES]) - (DW+1)'(r_rxb[STAGES]);
    assign n_dy = (DW+1)'(r_rya[STAGES]) - (DW+1)'(r_ryb[STAGES]);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dv <= 1'b0;
        else if (adv) r_dv <= r_rv[STAGES];
        if (adv) begin
            r_ds <= r_rs[STAGES]; r_dovm <= r_rovm[STAGES];
            r_rxo <= r_rxa[STAGES]; r_ryo <= r_rya[STAGES];
            r_dzero <= (n_dx == 0) && (n_dy == 0);
            if (n_dx < 0) begin
                r_dx <= -n_dx; r_dy <= -n_dy;
                r_dz <= (n_dy >= 0) ? Pi : -Pi;
            end else begin
                r_dx <= n_dx; r_dy <= n_dy; r_dz <= '0;
            end
        end
    end

    // vectoring pipeline
    localparam int VW = DW + 3;
    logic                 r_vv [STAGES+1];
    logic                 r_vovm [STAGES+1], r_vzero [STAGES+1];
    t_side                r_vs [STAGES+1];
    logic signed [DW-1:0] r_vxo [STAGES+1], r_vyo [STAGES+1];
    logic signed [VW-1:0] r_vx [STAGES+1], r_vy [STAGES+1];
    logic signed [35:0]   r_vz [STAGES+1];

    assign r_vv[0] = r_dv; assign r_vs[0] = r_ds; assign r_vovm[0] = r_dovm;
    assign r_vzero[0] = r_dzero; assign r_vxo[0] = r_rxo; assign r_vyo[0] = r_ryo;
    assign r_vx[0] = VW'(r_dx); assign r_vy[0] = VW'(r_dy); assign r_vz[0] = r_dz;

    for (genvar i = 0; i < STAGES; i++) begin : g_vec
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_vv[i+1] <= 1'b0;
            else if (adv) r_vv[i+1] <= r_vv[i];
            if (adv) begin
                r_vs[i+1] <= r_vs[i]; r_vovm[i+1] <= r_vovm[i];
                r_vzero[i+1] <= r_vzero[i];
                r_vxo[i+1] <= r_vxo[i]; r_vyo[i+1] <= r_vyo[i];
                if (r_vy[i] > 0) begin
                    r_vx[i+1] <= r_vx[i] + (r_vy[i] >>> i);
                    r_vy[i+1] <= r_vy[i] - (r_vx[i] >>> i);
                    r_vz[i+1] <= r_vz[i] + pca_pkg::atan_q32(i);
                end else begin
                    r_vx[i+1] <= r_vx[i] - (r_vy[i] >>> i);
                    r_vy[i+1] <= r_vy[i] + (r_vx[i] >>> i);
                    r_vz[i+1] <= r_vz[i] - pca_pkg::atan_q32(i);
                end
            end
        end
    end

    // finish: gain, rounding, wrap, saturation
    logic                 r_fv, r_fovm, r_fzero;
    t_side                r_fs;
    logic [VW-1:0]        r_fm;
    logic signed [35:0]   r_fz;
    logic signed [DW-1:0] r_fxo, r_fyo;
    logic [VW-1:0]        n_vxp;
    assign n_vxp = (r_vx[STAGES] > 0) ? VW'(r_vx[STAGES]) : '0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_fv <= 1'b0;
        else if (adv) r_fv <= r_vv[STAGES];
        if (adv) begin
            r_fs <= r_vs[STAGES]; r_fovm <= r_vovm[STAGES];
            r_fzero <= r_vzero[STAGES];
            r_fxo <= r_vxo[STAGES]; r_fyo <= r_vyo[STAGES];
            r_fm <= VW'(gain((RB+G+2)'(n_vxp)));
            r_fz <= r_vz[STAGES];
            if (r_vz[STAGES] > Pi) r_fz <= r_vz[STAGES] - (Pi <<< 1);
            else if (r_vz[STAGES] <= -Pi) r_fz <= r_vz[STAGES] + (Pi <<< 1);
        end
    end

    function automatic logic signed [AB-1:0] to_ang(input logic signed [35:0] z);
        logic signed [AB+1:0] v;
        v = (AB+2)'((z + (36'sd1 <<< (Sh-1))) >>> Sh);
        if (v > PA) v = v - (PA <<< 1);
        if (v <= -PA) v = v + (PA <<< 1);
        return AB'(v);
    endfunction

    function automatic logic signed [XB-1:0] to_xy(input logic signed [DW-1:0] a);
        logic signed [DW:0] v;
        v = ((DW+1)'(a) + (DW+1)'(1 << (G-1))) >>> G;
        if (v >= (DW+1)'(1 <<< (XB-1))) return {1'b0, {(XB-1){1'b1}}};
        if (v < -(DW+1)'(1 <<< (XB-1))) return {1'b1, {(XB-1){1'b0}}};
        return XB'(v);
    endfunction

    logic [VW-1:0] n_mr;
    assign n_mr = (r_fm + VW'(1 << (G-1))) >> G;

    logic                        r_ov;
    logic [RB-1:0]               r_rad;
    logic signed [AB-1:0]        r_ang;
    logic signed [XB-1:0]        r_x, r_y;
    logic                        r_ovf;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (adv) r_ov <= r_fv;
        if (adv) begin
            r_rad <= '0; r_ang <= '0; r_x <= '0; r_y <= '0; r_ovf <= 1'b0;
            unique case (r_fs.cmd)
                pca_pkg::CMD_MUL: begin
                    r_rad <= r_fs.prod; r_ovf <= r_fovm;
                    r_ang <= to_ang(r_fs.zs);
                end
                pca_pkg::CMD_SUB: begin
                    if (!r_fzero) begin
                        if (|n_mr[VW-1:RB]) begin
                            r_rad <= {RB{1'b1}}; r_ovf <= 1'b1;
                        end else begin
                            r_rad <= n_mr[RB-1:0];
                        end
                        r_ang <= to_ang(r_fz);
                    end
                end
                pca_pkg::CMD_RECT: begin
                    r_x <= to_xy(r_fxo); r_y <= to_xy(r_fyo);
                end
                default: ;
            endcase
        end
    end

    assign o_valid      = r_ov;
    assign o_radius_out = r_rad;
    assign o_angle_out  = r_ang;
    assign o_x_out      = r_x;
    assign o_y_out      = r_y;
    assign o_overflow   = r_ovf;
endmodule

[sv/polar_complex_alu.sv]
// Polar complex ALU: one transfer in and one result out per cycle while
// neither side stalls. A result passes through the front register, the queue,
// two set-up stages, the rotation and vectoring CORDIC chains, and the
// difference, finish and output registers. Depends on pca_pkg, pca_front,
// pca_queue, pca_back.
module polar_complex_alu #(
    parameter int CORDIC_STAGES = pca_pkg::DefStages,
    parameter int FRACTION_BITS = pca_pkg::DefFracBits
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [1:0]                       i_command,
    input  logic [FRACTION_BITS+7:0]         i_radius_a,
    input  logic signed [FRACTION_BITS+2:0]  i_angle_a,
    input  logic [FRACTION_BITS+7:0]         i_radius_b,
    input  logic signed [FRACTION_BITS+2:0]  i_angle_b,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [FRACTION_BITS+7:0]         o_radius_out,
    output logic signed [FRACTION_BITS+2:0]  o_angle_out,
    output logic signed [FRACTION_BITS+9:0]  o_x_out,
    output logic signed [FRACTION_BITS+9:0]  o_y_out,
    output logic                             o_overflow
);
    localparam int RB = FRACTION_BITS + 8;
    localparam int QW = 2 + 2 * RB + 72;

    logic               f_valid, f_stall, q_valid, q_stall;
    pca_pkg::t_cmd      f_cmd;
    logic [1:0]         q_cmd;
    logic [RB-1:0]      f_ra, f_rb, q_ra, q_rb;
    logic signed [35:0] f_za, f_zb, q_za, q_zb;

    pca_front #(.FRAC_BITS(FRACTION_BITS)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_command, .i_radius_a, .i_angle_a, .i_radius_b, .i_angle_b,
        .o_valid(f_valid), .i_stall(f_stall),
        .o_cmd(f_cmd), .o_ra(f_ra), .o_rb(f_rb), .o_za(f_za), .o_zb(f_zb)
    );

    pca_queue #(.W(QW)) u_queue (
        .i_clk, .i_rst_n,
        .i_valid(f_valid), .o_stall(f_stall),
        .i_data({f_cmd, f_ra, f_rb, f_za, f_zb}),
        .o_valid(q_valid), .i_stall(q_stall),
        .o_data({q_cmd, q_ra, q_rb, q_za, q_zb})
    );

    pca_back #(.STAGES(CORDIC_STAGES), .FRAC_BITS(FRACTION_BITS)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .o_stall(q_stall),
        .i_cmd(pca_pkg::t_cmd'(q_cmd)), .i_ra(q_ra), .i_rb(q_rb),
        .i_za(q_za), .i_zb(q_zb),
        .o_valid, .i_stall,
        .o_radius_out, .o_angle_out, .o_x_out, .o_y_out, .o_overflow
    );
endmodule

[sv/pca_checker.sv]
// Port-level checks for polar_complex_alu, bound to the top level.
// Depends on pca_pkg and the polar_complex_alu ports.
module pca_checker #(
    parameter int FRACTION_BITS = pca_pkg::DefFracBits
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_valid,
    input logic                            i_stall,
    input logic [FRACTION_BITS+7:0]        o_radius_out,
    input logic signed [FRACTION_BITS+2:0] o_angle_out,
    input logic signed [FRACTION_BITS+9:0] o_x_out,
    input logic                            o_overflow
);
    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflow |-> &o_radius_out) else $error("overflow without saturation");
    a_rect_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_x_out != 0 |-> o_radius_out == 0 && o_angle_out == 0)
        else $error("rectangular result with polar fields");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_radius_out))
        else $error("stalled result changed");
endmodule

bind polar_complex_alu pca_checker #(.FRACTION_BITS(FRACTION_BITS)) u_pca_checker (
    .i_clk, .i_rst_n, .o_valid, .i_stall, .o_radius_out, .o_angle_out,
    .o_x_out, .o_overflow
);

[bench/polar_complex_alu_tb.sv]
// Testbench for polar_complex_alu: drives polar operand pairs through the
// valid/stall channels and checks each result against a bit-exact predictor
// of the multiply, subtract and rectangular-conversion paths. Uses pca_pkg.
module polar_complex_alu_tb;

    localparam int Stages  = 16;
    localparam int Frac    = 16;
    localparam int RadBits = Frac + 8;
    localparam int AngBits = Frac + 3;
    localparam int XyBits  = Frac + 10;
    localparam int Latency = 2 * Stages + 7;

    typedef struct packed {
        logic [RadBits-1:0]        radius;
        logic signed [AngBits-1:0] angle;
        logic signed [XyBits-1:0]  x;
        logic signed [XyBits-1:0]  y;
        logic                      ovf;
    } t_polar_res;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_stall;
    logic [1:0]                  i_command;
    logic [RadBits-1:0]          i_radius_a;
    logic signed [AngBits-1:0]   i_angle_a;
    logic [RadBits-1:0]          i_radius_b;
    logic signed [AngBits-1:0]   i_angle_b;
    logic                        o_valid;
    logic                        i_stall;
    logic [RadBits-1:0]          o_radius_out;
    logic signed [AngBits-1:0]   o_angle_out;
    logic signed [XyBits-1:0]    o_x_out;
    logic signed [XyBits-1:0]    o_y_out;
    logic                        o_overflow;

    t_polar_res expected_q[$];
    int         errors;
    bit         rx_idle_en;
    int         hold_off;

    polar_complex_alu #(.CORDIC_STAGES(Stages), .FRACTION_BITS(Frac)) dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(12 * 3000000);
        $display("Regression FAIL");
        $finish;
    end

    function automatic longint sra(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint gain_scale(input longint u);
        longint hi, lo, g;
        g = longint'(pca_pkg::GainInvQ32);
        hi = u >>> 16;
        lo = u & 64'hFFFF;
        return (hi * g + ((lo * g) >>> 16) + 32768) >>> 16;
    endfunction

    function automatic longint wrap_pi(input longint z);
        longint pi;
        pi = longint'(pca_pkg::PiQ32);
        while (z > pi) z -= 2 * pi;
        while (z <= -pi) z += 2 * pi;
        return z;
    endfunction

    function automatic longint to_angle(input longint z);
        longint half, p, v;
        half = longint'(1) <<< (31 - Frac);
        p = sra(longint'(pca_pkg::PiQ32) + half, 32 - Frac);
        v = sra(z + half, 32 - Frac);
        if (v > p) v -= 2 * p;
        if (v <= -p) v += 2 * p;
        return v;
    endfunction

    task automatic cordic_rotate(input longint r, input longint z,
                                 output longint xo, output longint yo);
        longint x, y, t;
        x = gain_scale(r <<< pca_pkg::GuardBits);
        y = 0;
        z = wrap_pi(z);
        if (z > longint'(pca_pkg::HalfPiQ32)) begin
            z -= longint'(pca_pkg::PiQ32);
            x = -x;
        end else if (z < -longint'(pca_pkg::HalfPiQ32)) begin
            z += longint'(pca_pkg::PiQ32);
            x = -x;
        end
        for (int i = 0; i < Stages; i++) begin
            if (z >= 0) begin
                t = x - sra(y, i);
                y = y + sra(x, i);
                z -= longint'(pca_pkg::atan_q32(i));
            end else begin
                t = x + sra(y, i);
                y = y - sra(x, i);
                z += longint'(pca_pkg::atan_q32(i));
            end
            x = t;
        end
        xo = x;
        yo = y;
    endtask

    task automatic cordic_vector(input longint x, input longint y,
                                 output longint mag, output longint ang);
        longint z, t;
        z = 0;
        if (x == 0 && y == 0) begin
            mag = 0;
            ang = 0;
            return;
        end
        if (x < 0) begin
            z = (y >= 0) ? longint'(pca_pkg::PiQ32) : -longint'(pca_pkg::PiQ32);
            x = -x;
            y = -y;
        end
        for (int i = 0; i < Stages; i++) begin
            if (y > 0) begin
                t = x + sra(y, i);
                y = y - sra(x, i);
                z += longint'(pca_pkg::atan_q32(i));
            end else begin
                t = x - sra(y, i);
                y = y + sra(x, i);
                z -= longint'(pca_pkg::atan_q32(i));
            end
            x = t;
        end
        mag = (x > 0) ? gain_scale(x) : 0;
        ang = wrap_pi(z);
    endtask

    function automatic longint clamp_xy(input longint v);
        longint lim;
        lim = longint'(1) <<< (XyBits - 1);
        if (v >= lim) return lim - 1;
        if (v < -lim) return -lim;
        return v;
    endfunction

    task automatic predict_polar(input pca_pkg::t_cmd cmd, input logic [RadBits-1:0] ra,
                                 input logic signed [AngBits-1:0] aa,
                                 input logic [RadBits-1:0] rb,
                                 input logic signed [AngBits-1:0] ab,
                                 output t_polar_res res);
        longint rmask, za, zb, p, xa, ya, xb, yb, m, zq, h;
        rmask = (longint'(1) <<< RadBits) - 1;
        za = longint'(aa) <<< (32 - Frac);
        zb = longint'(ab) <<< (32 - Frac);
        h = longint'(1) <<< (pca_pkg::GuardBits - 1);
        res = '0;
        unique case (cmd)
            pca_pkg::CMD_MUL: begin
                p = (longint'(ra) * longint'(rb) + (longint'(1) <<< (Frac - 1))) >>> Frac;
                if (p > rmask) begin
                    p = rmask;
                    res.ovf = 1'b1;
                end
                res.radius = p[RadBits-1:0];
                res.angle = AngBits'(to_angle(wrap_pi(za + zb)));
            end
            pca_pkg::CMD_SUB: begin
                cordic_rotate(longint'(ra), za, xa, ya);
                cordic_rotate(longint'(rb), zb, xb, yb);
                cordic_vector(xa - xb, ya - yb, m, zq);
                m = (m + h) >>> pca_pkg::GuardBits;
                if (m > rmask) begin
                    m = rmask;
                    res.ovf = 1'b1;
                end
                res.radius = m[RadBits-1:0];
                res.angle = AngBits'(to_angle(zq));
            end
            pca_pkg::CMD_RECT: begin
                cordic_rotate(longint'(ra), za, xa, ya);
                res.x = XyBits'(clamp_xy(sra(xa + h, pca_pkg::GuardBits)));
                res.y = XyBits'(clamp_xy(sra(ya + h, pca_pkg::GuardBits)));
            end
            default: ;
        endcase
    endtask

    task automatic send_op(input pca_pkg::t_cmd cmd, input int ra, input int aa,
                           input int rb, input int ab, input bit gaps);
        t_polar_res                res;
        logic [RadBits-1:0]        ra_v, rb_v;
        logic signed [AngBits-1:0] aa_v, ab_v;
        ra_v = RadBits'(ra);
        rb_v = RadBits'(rb);
        aa_v = AngBits'(aa);
        ab_v = AngBits'(ab);
        if (gaps && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_command  <= cmd;
        i_radius_a <= ra_v;
        i_angle_a  <= aa_v;
        i_radius_b <= rb_v;
        i_angle_b  <= ab_v;
        predict_polar(cmd, ra_v, aa_v, rb_v, ab_v, res);
        do @(posedge i_clk); while (o_stall);
        expected_q.push_back(res);
    endtask

    task automatic end_burst();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_polar_res e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time,
                         {o_radius_out, o_angle_out, o_x_out, o_y_out, o_overflow});
                errors++;
            end else begin
                e = expected_q.pop_front();
                if (o_radius_out !== e.radius || o_angle_out !== e.angle ||
                    o_x_out !== e.x || o_y_out !== e.y || o_overflow !== e.ovf) begin
                    $display("%0t: mismatch expected r=%h a=%h x=%h y=%h o=%b", $time,
                             e.radius, e.angle, e.x, e.y, e.ovf);
                    $display("%0t:          actual   r=%h a=%h x=%h y=%h o=%b", $time,
                             o_radius_out, o_angle_out, o_x_out, o_y_out, o_overflow);
                    errors++;
                end
            end
        end
    end

    initial begin
        int n;
        i_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_off > 0) begin
                i_stall <= 1'b1;
                repeat (hold_off) @(posedge i_clk);
                hold_off = 0;
            end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                n = $urandom_range(1, 19);
                repeat (n) @(posedge i_clk);
            end else begin
                i_stall <= 1'b0;
                n = $urandom_range(1, 30);
                repeat (n) @(posedge i_clk);
            end
        end
    end

    function automatic int rand_radius();
        case ($urandom_range(0, 3))
            0: return int'($urandom_range(0, 65535 * 4));
            1: return int'($urandom_range(0, 16777215));
            2: return int'($urandom_range(0, 16 * 65536));
            default: return int'($urandom_range(0, 65536 * 2));
        endcase
    endfunction

    function automatic int rand_angle();
        return int'($urandom_range(0, 524287)) - 262144;
    endfunction

    task automatic test_directed();
        int rmax, amax, amin, pi_a;
        rmax = 16777215;
        amax = 262143;
        amin = -262144;
        pi_a = 205887;
        send_op(pca_pkg::CMD_MUL, 0, 0, 0, 0, 1'b0);
        send_op(pca_pkg::CMD_MUL, rmax, amax, rmax, amax, 1'b0);
        send_op(pca_pkg::CMD_MUL, 65536, amin, 65536, amin, 1'b0);
        send_op(pca_pkg::CMD_MUL, 65536, pi_a, 65536, pi_a, 1'b0);
        send_op(pca_pkg::CMD_MUL, 16 * 65536, 0, 16 * 65536, 0, 1'b0);
        send_op(pca_pkg::CMD_SUB, 65536, 1000, 65536, 1000, 1'b0);
        send_op(pca_pkg::CMD_SUB, 0, 0, 0, 0, 1'b0);
        send_op(pca_pkg::CMD_SUB, rmax, 0, rmax, pi_a, 1'b0);
        send_op(pca_pkg::CMD_SUB, 65536, pi_a, 0, 0, 1'b0);
        send_op(pca_pkg::CMD_SUB, 0, 0, 65536, 102944, 1'b0);
        send_op(pca_pkg::CMD_SUB, 0, 0, 65536, -102944, 1'b0);
        send_op(pca_pkg::CMD_SUB, 65536, amax, 2 * 65536, amin, 1'b0);
        send_op(pca_pkg::CMD_RECT, rmax, 0, 0, 0, 1'b0);
        send_op(pca_pkg::CMD_RECT, rmax, pi_a, 0, 0, 1'b0);
        send_op(pca_pkg::CMD_RECT, 65536, 102944, 0, 0, 1'b0);
        send_op(pca_pkg::CMD_RECT, 65536, -150000, 0, 0, 1'b0);
        send_op(pca_pkg::CMD_RECT, 3 * 65536, amin, rmax, amax, 1'b0);
        send_op(pca_pkg::CMD_NONE, rmax, amax, rmax, amin, 1'b0);
        send_op(pca_pkg::CMD_NONE, 0, 0, 0, 0, 1'b0);
        end_burst();
    endtask

    task automatic test_random(input int count, input bit gaps);
        pca_pkg::t_cmd c;
        for (int k = 0; k < count; k++) begin
            c = pca_pkg::t_cmd'($urandom_range(0, 15) == 0 ? 3 : $urandom_range(0, 2));
            send_op(c, rand_radius(), rand_angle(), rand_radius(), rand_angle(), gaps);
        end
        end_burst();
    endtask

    task automatic test_backpressure();
        hold_off = 300;
        test_random(150, 1'b0);
    endtask

    initial begin
        int guard;
        errors = 0;
        rx_idle_en = 0;
        hold_off = 0;
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_command  <= '0;
        i_radius_a <= '0;
        i_angle_a  <= '0;
        i_radius_b <= '0;
        i_angle_b  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        rx_idle_en = 1;
        test_random(1200, 1'b1);
        test_backpressure();
        rx_idle_en = 0;
        test_random(600, 1'b0);
        guard = 0;
        while (expected_q.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (Latency + 10) @(posedge i_clk);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
